FILE: sv/bounded_message_deque_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bounded message deque
// Shared concurrent-assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_MESSAGE_DEQUE_UNIT_DEFINES_SVH
`define BOUNDED_MESSAGE_DEQUE_UNIT_DEFINES_SVH

// same-cycle implication
`define BMD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BMD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bmd_pkg.sv
// ----------------------------------------------------------------------------
// bmd_pkg
// Shared codes, defaults and the controller-to-datapath command type.
// ----------------------------------------------------------------------------
package bmd_pkg;

    // default sizing
    localparam int DEF_DEPTH     = 16;
    localparam int DEF_MSG_WIDTH = 32;

    localparam int FUNC_W = 2;
    localparam int ST_W   = 2;

    // request operations
    localparam logic [FUNC_W-1:0] FUNC_SEND = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_RECV = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_JAM  = 2'd2;

    // result status codes
    localparam logic [ST_W-1:0] ST_DONE     = 2'd0;
    localparam logic [ST_W-1:0] ST_REFUSED  = 2'd1;
    localparam logic [ST_W-1:0] ST_DEFERRED = 2'd2;

    // commands from controller to datapath
    typedef struct packed {
        logic load;   // input transfer taken: latch request, read head slot
        logic exec;   // apply request, update state, load result registers
    } bmd_cmd_t;

endpackage

FILE: sv/bmd_ctrl.sv
// ----------------------------------------------------------------------------
// bmd_ctrl
// Request sequencer: accept, execute, then hold the result until taken.
// ----------------------------------------------------------------------------
`include "bounded_message_deque_unit_defines.svh"

module bmd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output bmd_pkg::bmd_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;

    // ready when empty, or when the held result leaves this cycle
    assign s_tready = (state_reg == S_IDLE) || ((state_reg == S_RESP) && m_tready);
    assign m_tvalid = valid_reg;
    assign cmd.load = s_tvalid && s_tready;
    assign cmd.exec = (state_reg == S_EXEC);

    // next state
    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.load)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_RESP;
                valid_next = 1'b1;
            end
            S_RESP:
            begin
                if (m_tready)
                begin
                    valid_next = 1'b0;
                    state_next = cmd.load ? S_EXEC : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    `BMD_ASSERT_NXT(a_exec_then_valid, cmd.exec, m_tvalid, "result not presented after execute")
    `BMD_ASSERT_NXT(a_load_then_exec, cmd.load, cmd.exec, "accepted request not executed")
    `BMD_ASSERT_IMP(a_valid_in_resp, m_tvalid, state_reg == S_RESP, "valid outside response state")

endmodule

FILE: sv/bmd_datapath.sv
// ----------------------------------------------------------------------------
// bmd_datapath
// Slot store, head and count registers, capacity register, result registers.
// ----------------------------------------------------------------------------
`include "bounded_message_deque_unit_defines.svh"

module bmd_datapath #(
    parameter  int DEPTH     = bmd_pkg::DEF_DEPTH,
    parameter  int MSG_WIDTH = bmd_pkg::DEF_MSG_WIDTH,
    localparam int IDX_W     = $clog2(DEPTH),
    localparam int CNT_W     = $clog2(DEPTH + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  bmd_pkg::bmd_cmd_t         cmd,
    input  logic                      cfg_wr_en,
    input  logic [CNT_W-1:0]          cfg_wr_data,
    input  logic [bmd_pkg::FUNC_W-1:0] func,
    input  logic [MSG_WIDTH-1:0]      message_in,
    input  logic                      wait_flag,
    output logic [bmd_pkg::ST_W-1:0]  status,
    output logic [MSG_WIDTH-1:0]      message_out,
    output logic [CNT_W-1:0]          occupancy
);

    logic [MSG_WIDTH-1:0] mem [DEPTH];

    // control state
    logic [CNT_W-1:0] cap_reg;
    logic [CNT_W-1:0] cap_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [CNT_W-1:0] used_reg;
    logic [CNT_W-1:0] used_next;

    // latched request and head slot read
    logic [bmd_pkg::FUNC_W-1:0] func_reg;
    logic [MSG_WIDTH-1:0]       msg_reg;
    logic                       wait_reg;
    logic [MSG_WIDTH-1:0]       rd_reg;

    // result registers
    logic [bmd_pkg::ST_W-1:0] status_reg;
    logic [bmd_pkg::ST_W-1:0] status_next;
    logic [MSG_WIDTH-1:0]     msg_out_reg;
    logic [MSG_WIDTH-1:0]     msg_out_next;
    logic [CNT_W-1:0]         occ_reg;

    // write port
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    // index arithmetic
    logic             full;
    logic             empty;
    logic [CNT_W:0]   tail_sum;
    logic [CNT_W:0]   tail_wrap;
    logic [CNT_W-1:0] head_inc;
    logic [IDX_W-1:0] head_dec;
    logic [CNT_W-1:0] cap_clamped;

    assign full     = (used_reg >= cap_reg);
    assign empty    = (used_reg == '0);
    assign tail_sum = (CNT_W+1)'(head_reg) + (CNT_W+1)'(used_reg);
    assign tail_wrap = (tail_sum >= (CNT_W+1)'(cap_reg)) ?
                       (tail_sum - (CNT_W+1)'(cap_reg)) : tail_sum;
    assign head_inc = CNT_W'(head_reg) + CNT_W'(1);
    assign head_dec = (head_reg == '0) ? IDX_W'(cap_reg - CNT_W'(1)) :
                      (head_reg - IDX_W'(1));

    // zero reads as one slot, anything above the store as the full store
    assign cap_clamped = (cfg_wr_data == '0) ? CNT_W'(1) :
                         (cfg_wr_data > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : cfg_wr_data;

    // request decode and next state
    always_comb
    begin
        cap_next     = cap_reg;
        head_next    = head_reg;
        used_next    = used_reg;
        status_next  = bmd_pkg::ST_DONE;
        msg_out_next = '0;
        mem_we       = 1'b0;
        mem_waddr    = tail_wrap[IDX_W-1:0];
        if (cfg_wr_en)
        begin
            cap_next  = cap_clamped;
            head_next = '0;
            used_next = '0;
        end
        else if (cmd.exec)
        begin
            case (func_reg)
                bmd_pkg::FUNC_SEND:
                begin
                    if (full)
                    begin
                        status_next = wait_reg ? bmd_pkg::ST_DEFERRED : bmd_pkg::ST_REFUSED;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        used_next = used_reg + CNT_W'(1);
                    end
                end
                bmd_pkg::FUNC_JAM:
                begin
                    if (full)
                    begin
                        status_next = wait_reg ? bmd_pkg::ST_DEFERRED : bmd_pkg::ST_REFUSED;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = head_dec;
                        head_next = head_dec;
                        used_next = used_reg + CNT_W'(1);
                    end
                end
                bmd_pkg::FUNC_RECV:
                begin
                    if (empty)
                    begin
                        status_next = wait_reg ? bmd_pkg::ST_DEFERRED : bmd_pkg::ST_REFUSED;
                    end
                    else
                    begin
                        msg_out_next = rd_reg;
                        head_next    = (head_inc >= cap_reg) ? '0 : head_inc[IDX_W-1:0];
                        used_next    = used_reg - CNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = bmd_pkg::ST_REFUSED;
                end
            endcase
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= CNT_W'(DEPTH);
            head_reg <= '0;
            used_reg <= '0;
        end
        else
        begin
            cap_reg  <= cap_next;
            head_reg <= head_next;
            used_reg <= used_next;
        end
    end

    // request latch and registered head read
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            msg_reg  <= message_in;
            wait_reg <= wait_flag;
            rd_reg   <= mem[head_reg];
        end
    end

    // slot store write
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= msg_reg;
        end
    end

    // result registers
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            status_reg  <= status_next;
            msg_out_reg <= msg_out_next;
            occ_reg     <= used_next;
        end
    end

    assign status      = status_reg;
    assign message_out = msg_out_reg;
    assign occupancy   = occ_reg;

    `BMD_ASSERT_IMP(a_used_le_cap, 1'b1, used_reg <= cap_reg, "occupancy above capacity")
    `BMD_ASSERT_IMP(a_head_lt_cap, 1'b1, CNT_W'(head_reg) < cap_reg, "head outside capacity")
    `BMD_ASSERT_IMP(a_cap_range, 1'b1, (cap_reg != '0) && (cap_reg <= CNT_W'(DEPTH)),
                    "capacity out of range")

endmodule

FILE: sv/bounded_message_deque_unit.sv
// ----------------------------------------------------------------------------
// bounded_message_deque_unit
// Circular message queue with send to tail, receive from head, jam to head.
// ----------------------------------------------------------------------------
// Requests arrive on the s_* stream: s_tuser carries the operation, s_tdata
// the message word and the blocking flag. Each request gives one result on
// the m_* stream: m_tuser carries the status, m_tdata the received message
// (zero unless a receive succeeded) and the occupancy after the request.
// The edge that takes a request latches it and registers the head slot
// read; the execute state then applies the request and loads the result
// registers. A new request is taken in the cycle the held result is
// transferred, so no request is taken while the one before it executes,
// owing to the registered slot-store read ahead of the update.
// When the receiver stalls, the result holds and no new request is taken.
// Reset empties the queue and sets capacity to DEPTH; slots need no
// clearing. A write on cfg_wr_en sets capacity (zero reads as 1, values
// above DEPTH as DEPTH) and empties the queue; write only while idle.
// ----------------------------------------------------------------------------
module bounded_message_deque_unit #(
    parameter  int DEPTH     = bmd_pkg::DEF_DEPTH,
    parameter  int MSG_WIDTH = bmd_pkg::DEF_MSG_WIDTH,
    localparam int CNT_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((MSG_WIDTH + 1 + 7) / 8) * 8,
    localparam int OUT_W     = ((MSG_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [CNT_W-1:0]           cfg_wr_data,   // capacity
    // request stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [IN_W-1:0]            s_tdata,       // message_in, wait_flag, zero pad
    input  logic [bmd_pkg::FUNC_W-1:0] s_tuser,       // func
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [OUT_W-1:0]           m_tdata,       // message_out, occupancy, zero pad
    output logic [bmd_pkg::ST_W-1:0]   m_tuser        // status
);

    bmd_pkg::bmd_cmd_t  cmd;
    logic [MSG_WIDTH-1:0] message_out;
    logic [CNT_W-1:0]     occupancy;

    bmd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bmd_datapath #(
        .DEPTH     (DEPTH),
        .MSG_WIDTH (MSG_WIDTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .func        (s_tuser),
        .message_in  (s_tdata[MSG_WIDTH-1:0]),
        .wait_flag   (s_tdata[MSG_WIDTH]),
        .status      (m_tuser),
        .message_out (message_out),
        .occupancy   (occupancy)
    );

    // pack result fields, lowest first
    assign m_tdata = OUT_W'({occupancy, message_out});

endmodule

FILE: tb/sv/bounded_message_deque_unit_tb.sv
// ----------------------------------------------------------------------------
// bounded_message_deque_unit_tb
// Self-checking bench for the bounded message deque. Requests go in on the
// s_* stream and a tracker class keeps its own copy of the slot store, head
// index, count and capacity. It works out the status, received message and
// occupancy for every accepted request. Each result transfer on the m_*
// stream is compared with the oldest pending result. A directed opening covers
// empty, full, wrap and unused-operation cases. Randomized phases with
// fill/drain bias then follow at several capacity settings. Both stream sides
// idle at random.
// ----------------------------------------------------------------------------
module bounded_message_deque_unit_tb;

    localparam int DEPTH      = bmd_pkg::DEF_DEPTH;
    localparam int MSG_W      = bmd_pkg::DEF_MSG_WIDTH;
    localparam int FUNC_W     = bmd_pkg::FUNC_W;
    localparam int ST_W       = bmd_pkg::ST_W;
    localparam int OCC_W      = $clog2(DEPTH + 1);
    localparam int IN_W       = ((MSG_W + 1 + 7) / 8) * 8;
    localparam int OUT_W      = ((MSG_W + OCC_W + 7) / 8) * 8;
    localparam int CYCLE_CAP  = 400000;
    localparam int PHASE_REQS = 140;
    localparam int N_PHASES   = 12;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

    // one result as seen on the m_* stream
    typedef struct {
        logic [ST_W-1:0]  status;
        logic [MSG_W-1:0] message;
        logic [OCC_W-1:0] occupancy;
    } deque_result_t;

    // ------------------------------------------------------------------------
    // Tracks the queue contents and checks results in order
    // ------------------------------------------------------------------------
    class deque_tracker;
        logic [MSG_W-1:0] slots [DEPTH];
        int unsigned      head_idx;
        int unsigned      held;
        int unsigned      eff_cap = DEPTH;
        deque_result_t    pending_results [$];
        int unsigned      mismatches;

        // capacity write: clamp and empty the queue
        function void set_capacity(logic [OCC_W-1:0] value);
            if (value == 0)
                eff_cap = 1;
            else if (value > DEPTH)
                eff_cap = DEPTH;
            else
                eff_cap = value;
            head_idx = 0;
            held     = 0;
        endfunction

        // apply one accepted request and queue the result it gives
        function void take_request(logic [FUNC_W-1:0] func, logic [MSG_W-1:0] msg,
                                   logic blocking);
            deque_result_t r;
            int unsigned   tail;
            r.status  = bmd_pkg::ST_DONE;
            r.message = '0;
            if (func == bmd_pkg::FUNC_SEND || func == bmd_pkg::FUNC_JAM)
            begin
                if (held >= eff_cap)
                    r.status = blocking ? bmd_pkg::ST_DEFERRED : bmd_pkg::ST_REFUSED;
                else if (func == bmd_pkg::FUNC_SEND)
                begin
                    tail = head_idx + held;
                    if (tail >= eff_cap)
                        tail -= eff_cap;
                    slots[tail] = msg;
                    held++;
                end
                else
                begin
                    head_idx = (head_idx == 0) ? eff_cap - 1 : head_idx - 1;
                    slots[head_idx] = msg;
                    held++;
                end
            end
            else if (func == bmd_pkg::FUNC_RECV)
            begin
                if (held == 0)
                    r.status = blocking ? bmd_pkg::ST_DEFERRED : bmd_pkg::ST_REFUSED;
                else
                begin
                    r.message = slots[head_idx];
                    head_idx++;
                    if (head_idx >= eff_cap)
                        head_idx = 0;
                    held--;
                end
            end
            else
                r.status = bmd_pkg::ST_REFUSED;
            r.occupancy = OCC_W'(held);
            pending_results.push_back(r);
        endfunction

        // compare one result transfer with the oldest pending result
        function void check_result(logic [ST_W-1:0] status, logic [MSG_W-1:0] message,
                                   logic [OCC_W-1:0] occupancy);
            deque_result_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d msg %h occ %0d",
                             status, message, occupancy);
                return;
            end
            want = pending_results.pop_front();
            if (status !== want.status || message !== want.message ||
                occupancy !== want.occupancy)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected status %0d msg %h occ %0d, ",
                              "got status %0d msg %h occ %0d"},
                             want.status, want.message, want.occupancy,
                             status, message, occupancy);
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT signals and instance
    // ------------------------------------------------------------------------
    logic              clk         = 1'b0;
    logic              rst_n       = 1'b0;
    logic              cfg_wr_en   = 1'b0;
    logic [OCC_W-1:0]  cfg_wr_data = '0;
    logic              s_tvalid    = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata     = '0;   // message_in, wait_flag, zero pad
    logic [FUNC_W-1:0] s_tuser     = '0;   // func
    logic              m_tvalid;
    logic              m_tready    = 1'b0;
    logic [OUT_W-1:0]  m_tdata;            // message_out, occupancy, zero pad
    logic [ST_W-1:0]   m_tuser;            // status

    deque_tracker tracker = new;
    int unsigned  send_burst;
    int unsigned  cycle_count;

    bounded_message_deque_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    initial
    begin
        while (cycle_count < CYCLE_CAP)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("bounded_message_deque_unit_tb: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: check each transfer, random back-pressure
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold;
        int unsigned pick;
        hold = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tuser, m_tdata[MSG_W-1:0],
                                     m_tdata[MSG_W+OCC_W-1:MSG_W]);
            if (hold > 0)
                hold--;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 50)
                begin
                    m_tready <= 1'b1;
                    hold = $urandom_range(1, 6);
                end
                else if (pick < 85)
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(1, 3);
                end
                else if (pick < 95)
                begin
                    // long stretch with no stall
                    m_tready <= 1'b1;
                    hold = $urandom_range(40, 120);
                end
                else
                begin
                    m_tready <= 1'b0;
                    hold = $urandom_range(10, 30);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // idle cycles before the next request: mostly none, a few long
    function automatic int unsigned next_gap();
        int unsigned pick;
        if (send_burst > 0)
        begin
            send_burst--;
            return 0;
        end
        pick = $urandom_range(0, 99);
        if (pick < 4)
        begin
            send_burst = $urandom_range(30, 100);
            return 0;
        end
        if (pick < 60)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(4, 20);
    endfunction

    // one request transfer; returns at the accepting edge
    task automatic push_request(logic [FUNC_W-1:0] func, logic [MSG_W-1:0] msg,
                                logic blocking);
        int unsigned gap;
        gap = next_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {{(IN_W-MSG_W-1){1'b0}}, blocking, msg};
        do
            @(posedge clk);
        while (!s_tready);
        tracker.take_request(func, msg, blocking);
    endtask

    // stop sending and wait for every pending result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
    endtask

    // capacity write while idle
    task automatic write_capacity(logic [OCC_W-1:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_capacity(value);
    endtask

    function automatic logic [MSG_W-1:0] pick_message();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return {1'b1, {(MSG_W-1){1'b0}}};
            default: return MSG_W'($urandom);
        endcase
    endfunction

    // random requests; bias shifts between filling, draining and mixed
    task automatic random_requests(int unsigned count);
        int unsigned       bias;
        int unsigned       pick;
        logic [FUNC_W-1:0] func;
        bias = 2;
        for (int unsigned i = 0; i < count; i++)
        begin
            if (i % 20 == 0)
                bias = $urandom_range(0, 2);
            pick = $urandom_range(0, 99);
            if (pick < 3)
                func = FUNC_UNUSED;
            else if (bias == 0)
                func = (pick < 45) ? bmd_pkg::FUNC_SEND :
                       (pick < 75) ? bmd_pkg::FUNC_JAM : bmd_pkg::FUNC_RECV;
            else if (bias == 1)
                func = (pick < 20) ? bmd_pkg::FUNC_SEND :
                       (pick < 35) ? bmd_pkg::FUNC_JAM : bmd_pkg::FUNC_RECV;
            else
                func = (pick < 35) ? bmd_pkg::FUNC_SEND :
                       (pick < 60) ? bmd_pkg::FUNC_JAM : bmd_pkg::FUNC_RECV;
            push_request(func, pick_message(), 1'($urandom_range(0, 1)));
            // hold off once in a while until everything is back
            if ($urandom_range(0, 199) == 0)
                drain_results();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        logic [OCC_W-1:0] caps [N_PHASES];
        caps = '{5'd1, 5'd0, 5'd2, 5'd31, 5'd17, 5'd3, 5'd16, 5'd5,
                 5'd4, 5'd8, 5'd0, 5'd0};
        caps[10] = OCC_W'($urandom_range(1, 16));
        caps[11] = OCC_W'($urandom_range(0, 31));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty queue at reset capacity, unused operation
        push_request(bmd_pkg::FUNC_RECV, 32'h0000_0000, 1'b0);
        push_request(bmd_pkg::FUNC_RECV, 32'hFFFF_FFFF, 1'b1);
        push_request(FUNC_UNUSED, 32'hDEAD_BEEF, 1'b0);
        push_request(FUNC_UNUSED, 32'hFFFF_FFFF, 1'b1);
        // send both extremes, jam twice so the head wraps below zero
        push_request(bmd_pkg::FUNC_SEND, 32'h0000_0000, 1'b0);
        push_request(bmd_pkg::FUNC_SEND, 32'hFFFF_FFFF, 1'b1);
        push_request(bmd_pkg::FUNC_JAM, 32'hA5A5_A5A5, 1'b0);
        push_request(bmd_pkg::FUNC_JAM, 32'h5A5A_5A5A, 1'b1);
        // drain, head wraps back past the top
        repeat (4) push_request(bmd_pkg::FUNC_RECV, 32'h0, 1'b0);
        push_request(bmd_pkg::FUNC_RECV, 32'h0, 1'b0);

        // single slot: full refused and deferred for send and jam
        write_capacity(5'd1);
        push_request(bmd_pkg::FUNC_SEND, 32'h1234_5678, 1'b0);
        push_request(bmd_pkg::FUNC_SEND, 32'h1111_1111, 1'b0);
        push_request(bmd_pkg::FUNC_SEND, 32'h2222_2222, 1'b1);
        push_request(bmd_pkg::FUNC_JAM, 32'h3333_3333, 1'b0);
        push_request(bmd_pkg::FUNC_JAM, 32'h4444_4444, 1'b1);
        push_request(bmd_pkg::FUNC_RECV, 32'h0, 1'b1);
        push_request(bmd_pkg::FUNC_JAM, 32'h8765_4321, 1'b1);
        push_request(bmd_pkg::FUNC_RECV, 32'h0, 1'b0);

        // random phases across capacity settings, extremes included
        for (int p = 0; p < N_PHASES; p++)
        begin
            write_capacity(caps[p]);
            random_requests(PHASE_REQS);
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0)
            $display("bounded_message_deque_unit_tb: PASS");
        else
            $display("bounded_message_deque_unit_tb: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+sv
sv/bmd_pkg.sv
sv/bmd_ctrl.sv
sv/bmd_datapath.sv
sv/bounded_message_deque_unit.sv
tb/sv/bounded_message_deque_unit_tb.sv
